// ===== hw/rtl/dfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_pkg
// Shared types and constants for the deduplicating key FIFO.
// ----------------------------------------------------------------------------
package dfs_pkg;

	localparam int KEY_W        = 32;
	localparam int CNT_W        = 7;
	localparam int QUEUE_DEPTH_D = 64;
	localparam int SEEN_DEPTH_D  = 256;

	typedef enum logic [2:0] {
		OP_PUSH    = 3'd0,
		OP_FPUSH   = 3'd1,
		OP_POP     = 3'd2,
		OP_POPF    = 3'd3,
		OP_QUERY   = 3'd4,
		OP_CLEAR   = 3'd5,
		OP_POPMANY = 3'd6,
		OP_NONE    = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_DUP   = 3'd1,
		ST_QFULL = 3'd2,
		ST_SFULL = 3'd3,
		ST_EMPTY = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE, S_DECODE, S_SCAN, S_WAIT, S_LOAD, S_EMIT
	} state_t;

	typedef struct packed {
		logic    cap;
		logic    scan_start;
		logic    enq;
		logic    deq;
		logic    clear;
		logic    mark;
		logic    unmark;
		logic    emit;
		status_t st;
		logic    found;
		logic    item;
		logic    last;
	} cmd_t;

	typedef struct packed {
		logic busy;
		op_t  op;
		logic q_empty;
		logic q_full;
		logic max_zero;
		logic scan_fin;
		logic hit;
		logic set_full;
		logic left_zero;
		logic out_free;
	} sts_t;

endpackage

// ===== hw/rtl/dfs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_ctrl
// Sequencer: decodes each word and steps the datapath through it.
// ----------------------------------------------------------------------------
module dfs_ctrl import dfs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t  state_q, state_d;
	status_t st_q, st_d;
	logic    found_q, found_d;
	logic    item_q, item_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= ST_OK;
			found_q <= 1'b0;
			item_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			found_q <= found_d;
			item_q  <= item_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		st_d     = st_q;
		found_d  = found_q;
		item_d   = item_q;
		cmd      = '0;
		cmd.st   = st_q;
		cmd.found = found_q;
		cmd.item = item_q;
		cmd.last = !(sts.op == OP_POPMANY && item_q) || sts.left_zero;
		in_stall = sts.busy || (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid && !sts.busy) begin
					cmd.cap = 1'b1;
					st_d    = ST_OK;
					found_d = 1'b0;
					item_d  = 1'b0;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.op)
					OP_PUSH, OP_FPUSH, OP_QUERY: begin
						cmd.scan_start = 1'b1;
						state_d = S_SCAN;
					end
					OP_POP, OP_POPF: begin
						if (sts.q_empty) begin
							st_d = ST_EMPTY;
							state_d = S_EMIT;
						end else begin
							state_d = S_WAIT;
						end
					end
					OP_POPMANY: begin
						if (sts.q_empty) begin
							st_d = ST_EMPTY;
							state_d = S_EMIT;
						end else if (sts.max_zero) begin
							state_d = S_EMIT;
						end else begin
							state_d = S_WAIT;
						end
					end
					OP_CLEAR: begin
						cmd.clear = 1'b1;
						state_d = S_EMIT;
					end
					default: state_d = S_EMIT;
				endcase
			end
			S_SCAN: begin
				if (sts.scan_fin) begin
					state_d = S_EMIT;
					case (sts.op)
						OP_PUSH: begin
							if (sts.hit) st_d = ST_DUP;
							else if (sts.q_full) st_d = ST_QFULL;
							else if (sts.set_full) st_d = ST_SFULL;
							else begin
								cmd.mark = 1'b1;
								cmd.enq  = 1'b1;
							end
						end
						OP_FPUSH: begin
							if (sts.q_full) st_d = ST_QFULL;
							else if (!sts.hit && sts.set_full) st_d = ST_SFULL;
							else begin
								cmd.mark = !sts.hit;
								cmd.enq  = 1'b1;
							end
						end
						OP_QUERY: found_d = sts.hit;
						OP_POPF: cmd.unmark = sts.hit;
						default: ;
					endcase
				end
			end
			S_WAIT: state_d = S_LOAD;
			S_LOAD: begin
				cmd.deq = 1'b1;
				item_d  = 1'b1;
				if (sts.op == OP_POPF) begin
					cmd.scan_start = 1'b1;
					state_d = S_SCAN;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.op == OP_POPMANY && item_q && !sts.left_zero)
						state_d = S_WAIT;
					else
						state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/dfs_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_dp
// Datapath: key queue, seen-set memory with scan unit, output register.
// ----------------------------------------------------------------------------
module dfs_dp import dfs_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_D,
	parameter int SEEN_DEPTH  = SEEN_DEPTH_D
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic [2:0]       opcode,
	input  logic [KEY_W-1:0] key_x,
	input  logic [KEY_W-1:0] key_y,
	input  logic [KEY_W-1:0] key_z,
	input  logic [CNT_W-1:0] max_count,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [2:0]       status,
	output logic             found,
	output logic             item_valid,
	output logic [KEY_W-1:0] out_x,
	output logic [KEY_W-1:0] out_y,
	output logic [KEY_W-1:0] out_z,
	output logic             last,
	output logic [CNT_W-1:0] queue_count
);

	localparam int QA = $clog2(QUEUE_DEPTH);
	localparam int QC = $clog2(QUEUE_DEPTH + 1);
	localparam int SA = $clog2(SEEN_DEPTH);
	localparam int SC = $clog2(SEEN_DEPTH + 1);
	localparam int KW = 3 * KEY_W;

	logic [KW-1:0]   q_mem [QUEUE_DEPTH];
	logic [KW:0]     s_mem [SEEN_DEPTH];

	op_t             op_q;
	logic [KW-1:0]   key_q;
	logic [CNT_W-1:0] max_q, left_q;
	logic [QA-1:0]   head_q, tail_q;
	logic [QC-1:0]   count_q;
	logic [SC-1:0]   scnt_q;
	logic [KW-1:0]   q_rd_q;
	logic            clr_q;
	logic [SA-1:0]   clr_addr_q;
	logic [SA-1:0]   sa_q, ra_s1, hit_addr_q, fr_addr_q;
	logic            iss_q, rdv_s1, fin_q, hit_q, frf_q;
	logic [KW:0]     rd_s1;
	logic            out_valid_q;
	logic [CNT_W-1:0] cnt7, take;

	assign cnt7 = CNT_W'(count_q);
	assign take = (max_count < cnt7) ? max_count : cnt7;

	assign sts.busy      = clr_q;
	assign sts.op        = op_q;
	assign sts.q_empty   = (count_q == '0);
	assign sts.q_full    = (count_q == QC'(QUEUE_DEPTH));
	assign sts.max_zero  = (max_q == '0);
	assign sts.scan_fin  = fin_q;
	assign sts.hit       = hit_q;
	assign sts.set_full  = (scnt_q == SC'(SEEN_DEPTH));
	assign sts.left_zero = (left_q == '0);
	assign sts.out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q  <= op_t'(opcode);
			key_q <= {key_x, key_y, key_z};
			max_q <= max_count;
		end else if (cmd.deq) begin
			key_q <= q_rd_q;
		end
		if (cmd.enq) q_mem[tail_q] <= key_q;
		q_rd_q <= q_mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			left_q  <= '0;
			scnt_q  <= '0;
		end else begin
			if (cmd.cap) left_q <= take;
			if (cmd.clear) begin
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
			end else if (cmd.enq) begin
				tail_q  <= (tail_q == QA'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
				count_q <= count_q + 1'b1;
			end else if (cmd.deq) begin
				head_q  <= (head_q == QA'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
				count_q <= count_q - 1'b1;
				if (left_q != '0) left_q <= left_q - 1'b1;
			end
			if (cmd.mark) scnt_q <= scnt_q + 1'b1;
			else if (cmd.unmark) scnt_q <= scnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) s_mem[clr_addr_q] <= '0;
		else if (cmd.mark) s_mem[fr_addr_q] <= {1'b1, key_q};
		else if (cmd.unmark) s_mem[hit_addr_q] <= {1'b0, key_q};
		rd_s1 <= s_mem[sa_q];
		ra_s1 <= sa_q;
		if (rdv_s1 && !fin_q && rd_s1[KW] && rd_s1[KW-1:0] == key_q) hit_addr_q <= ra_s1;
		if (rdv_s1 && !fin_q && !rd_s1[KW] && !frf_q) fr_addr_q <= ra_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			sa_q       <= '0;
			iss_q      <= 1'b0;
			rdv_s1     <= 1'b0;
			fin_q      <= 1'b0;
			hit_q      <= 1'b0;
			frf_q      <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == SA'(SEEN_DEPTH - 1)) clr_q <= 1'b0;
			end
			if (cmd.scan_start) begin
				sa_q   <= '0;
				iss_q  <= 1'b1;
				rdv_s1 <= 1'b0;
				fin_q  <= 1'b0;
				hit_q  <= 1'b0;
				frf_q  <= 1'b0;
			end else begin
				rdv_s1 <= iss_q;
				if (iss_q) begin
					sa_q <= sa_q + 1'b1;
					if (sa_q == SA'(SEEN_DEPTH - 1)) iss_q <= 1'b0;
				end
				if (rdv_s1 && !fin_q) begin
					if (!rd_s1[KW]) frf_q <= 1'b1;
					if (rd_s1[KW] && rd_s1[KW-1:0] == key_q) begin
						hit_q <= 1'b1;
						fin_q <= 1'b1;
						iss_q <= 1'b0;
					end else if (ra_s1 == SA'(SEEN_DEPTH - 1)) begin
						fin_q <= 1'b1;
						iss_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.emit) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status      <= cmd.st;
			found       <= cmd.found;
			item_valid  <= cmd.item;
			out_x       <= cmd.item ? key_q[KW-1 -: KEY_W] : '0;
			out_y       <= cmd.item ? key_q[KW-KEY_W-1 -: KEY_W] : '0;
			out_z       <= cmd.item ? key_q[KEY_W-1:0] : '0;
			last        <= cmd.last;
			queue_count <= (op_q == OP_POPMANY) ? cnt7 - left_q : cnt7;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/dedup_fifo_with_seen_set_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dedup_fifo_with_seen_set_unit
// Key FIFO with a set of seen keys; push refuses keys already seen.
// ----------------------------------------------------------------------------
// channel | direction | handshake          | fields
// in      | to block  | in_valid/in_stall  | opcode key_x key_y key_z max_count
// out     | from block| out_valid/out_stall| status found item_valid out_x out_y
//         |           |                    | out_z last queue_count
// One word at a time. Push, force push and query scan the seen-set memory
// one slot a cycle; pop and forget adds such a scan to a pop. Pop many
// returns each key that it pops as a result word of its own.
// After reset a clearing pass over every seen-set slot holds in_stall high.
// out_stall holds the result register and the sequencer.
// ----------------------------------------------------------------------------
module dedup_fifo_with_seen_set_unit import dfs_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_D,
	parameter int SEEN_DEPTH  = SEEN_DEPTH_D
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [2:0]       opcode,
	input  logic [KEY_W-1:0] key_x,
	input  logic [KEY_W-1:0] key_y,
	input  logic [KEY_W-1:0] key_z,
	input  logic [CNT_W-1:0] max_count,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [2:0]       status,
	output logic             found,
	output logic             item_valid,
	output logic [KEY_W-1:0] out_x,
	output logic [KEY_W-1:0] out_y,
	output logic [KEY_W-1:0] out_z,
	output logic             last,
	output logic [CNT_W-1:0] queue_count
);

	cmd_t cmd;
	sts_t sts;

	dfs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.sts(sts), .cmd(cmd)
	);

	dfs_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .SEEN_DEPTH(SEEN_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.opcode(opcode), .key_x(key_x), .key_y(key_y), .key_z(key_z),
		.max_count(max_count), .out_valid(out_valid), .out_stall(out_stall),
		.status(status), .found(found), .item_valid(item_valid),
		.out_x(out_x), .out_y(out_y), .out_z(out_z), .last(last),
		.queue_count(queue_count)
	);

endmodule

// ===== hw/rtl/dfs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_checker
// Port-level checks for the deduplicating key FIFO.
// ----------------------------------------------------------------------------
module dfs_checker import dfs_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic             item_valid,
	input logic             last,
	input logic [KEY_W-1:0] out_x
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out word dropped while stalled");

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second word taken while busy");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !item_valid |-> last)
		else $error("keyless result not marked last");

	a_empty_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !item_valid |-> out_x == '0)
		else $error("keyless result carries key bits");

endmodule

bind dedup_fifo_with_seen_set_unit dfs_checker u_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .item_valid(item_valid),
	.last(last), .out_x(out_x)
);
